/* rtl/pfhi_pkg.sv */
`default_nettype none

package pfhi_pkg;

  localparam int unsigned HEADER_BYTES    = 4;
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [15:0] RST_SINGLE_LIMIT = 16'd1028;
  localparam logic [15:0] RST_FRAG_SIZE    = 16'd1024;
  localparam logic [7:0]  RST_REG_TYPE     = 8'd0;
  localparam logic [7:0]  RST_FRAG_TYPE    = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SINGLE_LIMIT = 2'd0,
    CFG_FRAG_SIZE    = 2'd1,
    CFG_REG_TYPE     = 2'd2,
    CFG_FRAG_TYPE    = 2'd3
  } cfg_idx_e;

  // one classified request: payload byte plus everything its header needs
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] dest;
    logic        hdr;
    logic [7:0]  type_code;
    logic [7:0]  frag_idx;
    logic [15:0] seq;
    logic        pend;
    logic        mend;
  } pfhi_entry_t;

endpackage

`default_nettype wire

/* rtl/pfhi_front.sv */
`default_nettype none

module pfhi_front
  import pfhi_pkg::*;
#(
  parameter int unsigned LengthBits = LENGTH_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            payload_byte_i,
  input  wire logic [LengthBits-1:0] message_length_i,
  input  wire logic [15:0]           destination_tag_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output pfhi_entry_t                q_entry_o
);

  localparam int unsigned CmpW = ((LengthBits > 16) ? LengthBits : 16) + 1;

  logic [15:0] limit_q, fsize_q;
  logic [7:0]  reg_type_q, frag_type_q;

  logic [15:0]           seq_q, seq_d;
  logic [LengthBits-1:0] msg_pos_q, msg_pos_d;
  logic [LengthBits-1:0] frag_pos_q, frag_pos_d;
  logic [7:0]            frag_idx_q, frag_idx_d;
  logic                  fragmenting_q, fragmenting_d;

  logic        accept;
  logic        frag_now, hdr, mend, pend;
  logic [15:0] fsize_eff;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= RST_SINGLE_LIMIT;
      fsize_q     <= RST_FRAG_SIZE;
      reg_type_q  <= RST_REG_TYPE;
      frag_type_q <= RST_FRAG_TYPE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SINGLE_LIMIT: limit_q     <= cfg_data_i[15:0];
        CFG_FRAG_SIZE:    fsize_q     <= cfg_data_i[15:0];
        CFG_REG_TYPE:     reg_type_q  <= cfg_data_i[7:0];
        CFG_FRAG_TYPE:    frag_type_q <= cfg_data_i[7:0];
        default:          limit_q     <= limit_q;
      endcase
    end
  end

  // classify the byte against the message and fragment counters
  always_comb begin
    fsize_eff = (fsize_q == 16'd0) ? 16'd1 : fsize_q;
    frag_now  = (msg_pos_q == '0) ? (CmpW'(message_length_i) > CmpW'(limit_q))
                                  : fragmenting_q;
    hdr       = (frag_pos_q == '0);
    mend      = (CmpW'(msg_pos_q) + CmpW'(1)) >= CmpW'(message_length_i);
    pend      = mend || (frag_now && ((CmpW'(frag_pos_q) + CmpW'(1)) >= CmpW'(fsize_eff)));
  end

  always_comb begin
    q_push_o            = accept;
    q_entry_o.data      = payload_byte_i;
    q_entry_o.dest      = destination_tag_i;
    q_entry_o.hdr       = hdr;
    q_entry_o.type_code = frag_now ? frag_type_q : reg_type_q;
    q_entry_o.frag_idx  = frag_now ? frag_idx_q : 8'd0;
    q_entry_o.seq       = seq_q;
    q_entry_o.pend      = pend;
    q_entry_o.mend      = mend;
  end

  always_comb begin
    seq_d         = seq_q;
    msg_pos_d     = msg_pos_q;
    frag_pos_d    = frag_pos_q;
    frag_idx_d    = frag_idx_q;
    fragmenting_d = fragmenting_q;
    if (accept) begin
      if (mend) begin
        seq_d         = seq_q + 16'd1;
        msg_pos_d     = '0;
        frag_pos_d    = '0;
        frag_idx_d    = 8'd0;
        fragmenting_d = 1'b0;
      end else begin
        msg_pos_d     = msg_pos_q + LengthBits'(1);
        fragmenting_d = frag_now;
        if (pend) begin
          frag_pos_d = '0;
          frag_idx_d = frag_idx_q + 8'd1;
        end else begin
          frag_pos_d = frag_pos_q + LengthBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= '0;
      msg_pos_q     <= '0;
      frag_pos_q    <= '0;
      frag_idx_q    <= '0;
      fragmenting_q <= 1'b0;
    end else begin
      seq_q         <= seq_d;
      msg_pos_q     <= msg_pos_d;
      frag_pos_q    <= frag_pos_d;
      frag_idx_q    <= frag_idx_d;
      fragmenting_q <= fragmenting_d;
    end
  end

  a_mend_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mend |=> (msg_pos_q == '0) && (frag_pos_q == '0) && !fragmenting_q)
    else $error("message end did not restart counters");

endmodule

`default_nettype wire

/* rtl/pfhi_queue.sv */
`default_nettype none

module pfhi_queue
  import pfhi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire pfhi_entry_t  entry_i,
  input  wire logic         pop_i,
  output logic              full_o,
  output logic              valid_o,
  output pfhi_entry_t       head_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  pfhi_entry_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || full_o |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step with count");

endmodule

`default_nettype wire

/* rtl/pfhi_back.sv */
`default_nettype none

module pfhi_back
  import pfhi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  wire pfhi_entry_t  q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [7:0]        packet_byte_o,
  output logic              is_header_o,
  output logic              packet_end_o,
  output logic              message_end_o,
  output logic              run_last_o,
  output logic [15:0]       destination_out_o
);

  localparam int unsigned PhW = $clog2(HEADER_BYTES + 1);

  logic           valid_q, valid_d;
  logic [PhW-1:0] phase_q, phase_d;
  logic [7:0]     byte_q, byte_d;
  logic           hdr_q, hdr_d, pend_q, pend_d, mend_q, mend_d, last_q, last_d;
  logic [15:0]    dest_q, dest_d;
  logic           advance;
  logic [7:0]     hdr_byte;

  assign advance = !valid_q || !out_stall_i;

  always_comb begin
    unique case (phase_q[1:0])
      2'd0:    hdr_byte = q_head_i.type_code;
      2'd1:    hdr_byte = q_head_i.frag_idx;
      2'd2:    hdr_byte = q_head_i.seq[15:8];
      default: hdr_byte = q_head_i.seq[7:0];
    endcase
  end

  // walk the header bytes, then the payload byte, which retires the request
  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    byte_d  = byte_q;
    hdr_d   = hdr_q;
    pend_d  = pend_q;
    mend_d  = mend_q;
    last_d  = last_q;
    dest_d  = dest_q;
    q_pop_o = 1'b0;
    if (advance) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        dest_d = q_head_i.dest;
        if (q_head_i.hdr && (phase_q < PhW'(HEADER_BYTES))) begin
          byte_d  = hdr_byte;
          hdr_d   = 1'b1;
          pend_d  = 1'b0;
          mend_d  = 1'b0;
          last_d  = 1'b0;
          phase_d = phase_q + PhW'(1);
        end else begin
          byte_d  = q_head_i.data;
          hdr_d   = 1'b0;
          pend_d  = q_head_i.pend;
          mend_d  = q_head_i.mend;
          last_d  = 1'b1;
          phase_d = '0;
          q_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    hdr_q  <= hdr_d;
    pend_q <= pend_d;
    mend_q <= mend_d;
    last_q <= last_d;
    dest_q <= dest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= '0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign packet_byte_o     = byte_q;
  assign is_header_o       = hdr_q;
  assign packet_end_o      = pend_q;
  assign message_end_o     = mend_q;
  assign run_last_o        = last_q;
  assign destination_out_o = dest_q;

  a_mid_header_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != '0) |-> q_valid_i && valid_q && hdr_q)
    else $error("header in progress without its request");

  a_header_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && hdr_q |-> !pend_q && !mend_q && !last_q)
    else $error("end flags set on a header byte");

  a_msg_end_pkt_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && mend_q |-> pend_q && last_q)
    else $error("message end without packet end");

endmodule

`default_nettype wire

/* rtl/packet_fragmenter_header_insert.sv */
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we_i                  cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_stall_o   payload_byte_i, message_length_i,
//                                                destination_tag_i
// out       out        out_valid_o / out_stall_i packet_byte_o, is_header_o, packet_end_o,
//                                                message_end_o, run_last_o,
//                                                destination_out_o
//
// A payload byte that opens a packet is preceded by 4 header bytes; the output register
// emits one byte per cycle while out_stall_i is low.
// The front classifies one byte per cycle into a 2-entry queue; in_stall_o rises only
// when that queue is full; accepted bytes pass the queue, then the output register.
// rst_ni clears counters, sequence number, queue and output valid; registers take
// their documented reset values.
`default_nettype none

module packet_fragmenter_header_insert
  import pfhi_pkg::*;
#(
  parameter int unsigned LengthBits = LENGTH_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            payload_byte_i,
  input  wire logic [LengthBits-1:0] message_length_i,
  input  wire logic [15:0]           destination_tag_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 packet_byte_o,
  output logic                       is_header_o,
  output logic                       packet_end_o,
  output logic                       message_end_o,
  output logic                       run_last_o,
  output logic [15:0]                destination_out_o
);

  logic        q_full, q_push, q_pop, q_valid;
  pfhi_entry_t q_entry, q_head;

  pfhi_front #(
    .LengthBits(LengthBits)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .message_length_i (message_length_i),
    .destination_tag_i(destination_tag_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_entry_o        (q_entry)
  );

  pfhi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (q_head)
  );

  pfhi_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .packet_byte_o    (packet_byte_o),
    .is_header_o      (is_header_o),
    .packet_end_o     (packet_end_o),
    .message_end_o    (message_end_o),
    .run_last_o       (run_last_o),
    .destination_out_o(destination_out_o)
  );

endmodule

`default_nettype wire
